// ===== rtl/clk7s_pkg.sv =====
// shared types, constants and digit helpers for the seven-segment clock
package clk7s_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned ScanW = $clog2(DigitCount);

  localparam logic [15:0] DefaultTicksPerSecond = 16'd1000;
  localparam logic [4:0]  ResetHours   = 5'd23;
  localparam logic [5:0]  ResetMinutes = 6'd59;
  localparam logic [5:0]  ResetSeconds = 6'd30;

  localparam logic [4:0] HoursPerDay   = 5'd24;
  localparam logic [5:0] SecsPerMinute = 6'd60;
  localparam logic [5:0] MinsPerHour   = 6'd60;

  localparam logic [7:0] DotBit = 8'h80;
  localparam logic [7:0] BlankGlyph = 8'h00;

  typedef struct packed {
    logic step;
    logic wrap;
    logic mode;
    logic blink;
  } scan_ctrl_t;

  // tens digit of a value below 64
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  // ones digit of a value below 64
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] r;
    t = tens_of(v);
    r = v - ({t, 3'b000} + {2'b00, t, 1'b0});
    return r[3:0];
  endfunction

  function automatic logic [7:0] glyph_of(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0: g = 8'h3F;
      4'd1: g = 8'h06;
      4'd2: g = 8'h5B;
      4'd3: g = 8'h4F;
      4'd4: g = 8'h66;
      4'd5: g = 8'h6D;
      4'd6: g = 8'h7D;
      4'd7: g = 8'h07;
      4'd8: g = 8'h7F;
      4'd9: g = 8'h6F;
      default: g = BlankGlyph;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/clk7s_scan.sv =====
// display buffer, digit scan and held segment outputs
module clk7s_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clk7s_pkg::scan_ctrl_t ctrl_i,
  input  logic [4:0]            hours_i,
  input  logic [5:0]            minutes_i,
  input  logic [5:0]            seconds_i,
  output logic [7:0]            segments_o,
  output logic [clk7s_pkg::DigitCount-1:0] digit_o
);

  logic [clk7s_pkg::DigitCount-1:0][7:0] buffer_q, fill;
  logic [clk7s_pkg::ScanW-1:0]           scan_q;
  logic [7:0]                            held_seg_q;
  logic [clk7s_pkg::DigitCount-1:0]      held_digit_q;
  logic [5:0]                            hi_val, lo_val;

  always_comb begin
    hi_val = ctrl_i.mode ? {1'b0, hours_i} : minutes_i;
    lo_val = ctrl_i.mode ? minutes_i : seconds_i;
    fill[3] = clk7s_pkg::glyph_of({1'b0, clk7s_pkg::tens_of(hi_val)});
    fill[2] = clk7s_pkg::glyph_of(clk7s_pkg::ones_of(hi_val)) | clk7s_pkg::DotBit;
    fill[1] = clk7s_pkg::glyph_of({1'b0, clk7s_pkg::tens_of(lo_val)});
    fill[0] = clk7s_pkg::glyph_of(clk7s_pkg::ones_of(lo_val))
            | ((ctrl_i.mode && ctrl_i.blink) ? clk7s_pkg::DotBit : 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_q     <= '0;
      scan_q       <= '0;
      held_seg_q   <= '0;
      held_digit_q <= '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.wrap) begin
        buffer_q <= fill;
      end else begin
        held_seg_q   <= buffer_q[scan_q];
        held_digit_q <= clk7s_pkg::DigitCount'(1) << scan_q;
        scan_q       <= scan_q + 1'b1;
      end
    end
  end

  assign segments_o = held_seg_q;
  assign digit_o    = held_digit_q;

endmodule

// ===== rtl/clock_with_seven_segment_mux.sv =====
// top level of the multiplexed four-digit seven-segment clock
// result: out_valid rises in the cycle after a tick is accepted
// throughput: one tick per cycle while out_ready holds, set by the single output register stage
// the output register is the clock state itself and is refilled as it drains
// reset: time 23:59:30, MM:SS mode, blank buffer, 1000 ticks per second
module clock_with_seven_segment_mux (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        button_pressed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  segment_pattern_o,
  output logic [3:0]  digit_enable_o,
  output logic [4:0]  clock_hours_o,
  output logic [5:0]  clock_minutes_o,
  output logic [5:0]  clock_seconds_o,
  output logic        showing_hours_o
);

  logic [15:0] tps_q, tick_q, tick_d, tick_inc;
  logic [4:0]  hours_q, hours_d;
  logic [5:0]  minutes_q, minutes_d, seconds_q, seconds_d;
  logic        blink_q, blink_d, mode_q, mode_d;
  logic        out_valid_q, accept, wrap;
  clk7s_pkg::scan_ctrl_t scan_ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_inc   = tick_q + 16'd1;
  assign wrap       = (tick_inc == tps_q);

  always_comb begin
    tick_d    = tick_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    blink_d   = blink_q;
    mode_d    = mode_q;
    if (accept) begin
      tick_d = wrap ? 16'd0 : tick_inc;
      if (wrap) begin
        mode_d    = mode_q ^ button_pressed_i;
        seconds_d = seconds_q + 6'd1;
        blink_d   = seconds_d[0];
        if (seconds_d == clk7s_pkg::SecsPerMinute) begin
          seconds_d = 6'd0;
          minutes_d = minutes_q + 6'd1;
        end
        if (minutes_d == clk7s_pkg::MinsPerHour) begin
          minutes_d = 6'd0;
          hours_d   = hours_q + 5'd1;
        end
        if (hours_d == clk7s_pkg::HoursPerDay) begin
          hours_d = 5'd0;
        end
      end
    end
  end

  always_comb begin
    scan_ctrl.step  = accept;
    scan_ctrl.wrap  = wrap;
    scan_ctrl.mode  = mode_d;
    scan_ctrl.blink = blink_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= clk7s_pkg::DefaultTicksPerSecond;
      tick_q      <= '0;
      hours_q     <= clk7s_pkg::ResetHours;
      minutes_q   <= clk7s_pkg::ResetMinutes;
      seconds_q   <= clk7s_pkg::ResetSeconds;
      blink_q     <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      tick_q      <= tick_d;
      hours_q     <= hours_d;
      minutes_q   <= minutes_d;
      seconds_q   <= seconds_d;
      blink_q     <= blink_d;
      mode_q      <= mode_d;
      out_valid_q <= accept || (out_valid_q && !out_ready_i);
    end
  end

  clk7s_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .hours_i    (hours_q),
    .minutes_i  (minutes_q),
    .seconds_i  (seconds_q),
    .segments_o (segment_pattern_o),
    .digit_o    (digit_enable_o)
  );

  assign out_valid_o     = out_valid_q;
  assign clock_hours_o   = hours_q;
  assign clock_minutes_o = minutes_q;
  assign clock_seconds_o = seconds_q;
  assign showing_hours_o = mode_q;

  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(digit_enable_o))
    else $error("digit enable not one-hot");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_seconds_o < clk7s_pkg::SecsPerMinute && clock_minutes_o < clk7s_pkg::MinsPerHour
    && clock_hours_o < clk7s_pkg::HoursPerDay)
    else $error("time out of range");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_time_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(clock_seconds_o) && $stable(showing_hours_o))
    else $error("clock state changed without a transaction");

endmodule
